// File: sv/rle62_pkg.sv
// Shared types, constants and palette ROM for the run-length palette image decoder.
package rle62_pkg;

  localparam int LINE_WIDTH_DEF    = 320;
  localparam int POSITION_BITS_DEF = 24;

  localparam int COUNT_W = 18;
  localparam int WIDTH_W = 22;
  localparam int COORD_W = 24;
  localparam int COLOR_W = 24;

  localparam logic [7:0] ESCAPE_BYTE = 8'h2a;  // '*'
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_Z      = 8'h5a;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X    = 2'd0,
    CFG_ORIGIN_Y    = 2'd1,
    CFG_PIXEL_SCALE = 2'd2
  } cfg_index_e;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_DIGIT1 = 5'b00010,
    PH_DIGIT2 = 5'b00100,
    PH_DIGIT3 = 5'b01000,
    PH_COLOR  = 5'b10000
  } phase_e;

  // One rectangle waiting for its screen coordinates.
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [3:0]         color;
    logic               last;
  } desc_t;

  function automatic logic [COLOR_W-1:0] palette(input logic [3:0] idx);
    logic [COLOR_W-1:0] rgb;
    unique case (idx)
      4'd0:  rgb = 24'hffffff;
      4'd1:  rgb = 24'ha7dcf3;
      4'd2:  rgb = 24'h669fe5;
      4'd3:  rgb = 24'h3eb8f2;
      4'd4:  rgb = 24'h69dff7;
      4'd5:  rgb = 24'hd2fdfc;
      4'd6:  rgb = 24'h000000;
      4'd7:  rgb = 24'ha3fbfc;
      4'd8:  rgb = 24'hb8fffa;
      4'd9:  rgb = 24'h47f7f9;
      4'd10: rgb = 24'h1f8ff3;
      4'd11: rgb = 24'h1063cc;
      4'd12: rgb = 24'h2c7af7;
      4'd13: rgb = 24'h0f48ca;
      4'd14: rgb = 24'h0b2dc2;
      4'd15: rgb = 24'h0710b8;
    endcase
    return rgb;
  endfunction

endpackage

// File: sv/rle_base62_palette_image_decoder.sv
// Top level of the run-length palette image decoder: configuration registers and datapath.
// Takes one encoded image byte per cycle unless in_stall_o is high, turning it into
// fill-rectangle commands. An escape or count digit draws nothing, a plain byte one
// rectangle, a colour byte closing a run two (one if it is the escape), stalling the
// input while the second waits in the queue. A rectangle passes through the parser's
// queue slot, the reciprocal multiply that splits the position into column and row,
// the remainder stage and the scale/offset stage. The user must write configuration
// through the cfg port only while no item is in flight; the block does not enforce this.
module rle_base62_palette_image_decoder #(
  parameter int LINE_WIDTH    = rle62_pkg::LINE_WIDTH_DEF,
  parameter int POSITION_BITS = rle62_pkg::POSITION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [1:0]                           cfg_index_i,
  input  logic [15:0]                          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           code_byte_i,
  input  logic                                 start_of_image_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rle62_pkg::COORD_W-1:0] rect_x_o,
  output logic signed [rle62_pkg::COORD_W-1:0] rect_y_o,
  output logic [rle62_pkg::WIDTH_W-1:0]        rect_width_o,
  output logic [3:0]                           rect_height_o,
  output logic [rle62_pkg::COLOR_W-1:0]        fill_color_o,
  output logic                                 last_of_run_o
);

  logic signed [15:0]       origin_x_q, origin_y_q;
  logic [3:0]               scale_q;
  logic                     desc_valid, desc_ready;
  logic [POSITION_BITS-1:0] desc_pos;
  rle62_pkg::desc_t         desc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      scale_q    <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rle62_pkg::CFG_ORIGIN_X:    origin_x_q <= cfg_data_i;
        rle62_pkg::CFG_ORIGIN_Y:    origin_y_q <= cfg_data_i;
        rle62_pkg::CFG_PIXEL_SCALE: scale_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  rle62_parser #(
    .PosBits (POSITION_BITS)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .scale_i          (scale_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .code_byte_i      (code_byte_i),
    .start_of_image_i (start_of_image_i),
    .desc_valid_o     (desc_valid),
    .desc_ready_i     (desc_ready),
    .desc_pos_o       (desc_pos),
    .desc_o           (desc)
  );

  rle62_coord #(
    .LineWidth (LINE_WIDTH),
    .PosBits   (POSITION_BITS)
  ) u_coord (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .origin_x_i    (origin_x_q),
    .origin_y_i    (origin_y_q),
    .scale_i       (scale_q),
    .desc_valid_i  (desc_valid),
    .desc_ready_o  (desc_ready),
    .desc_pos_i    (desc_pos),
    .desc_i        (desc),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rect_x_o      (rect_x_o),
    .rect_y_o      (rect_y_o),
    .rect_width_o  (rect_width_o),
    .rect_height_o (rect_height_o),
    .fill_color_o  (fill_color_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: sv/rle62_parser.sv
// Byte parser: escape/count state, linear pixel position and a two-slot rectangle queue.
module rle62_parser #(
  parameter int PosBits = rle62_pkg::POSITION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           scale_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           code_byte_i,
  input  logic                 start_of_image_i,
  output logic                 desc_valid_o,
  input  logic                 desc_ready_i,
  output logic [PosBits-1:0]   desc_pos_o,
  output rle62_pkg::desc_t     desc_o
);

  localparam int CW = rle62_pkg::COUNT_W;
  localparam int WW = rle62_pkg::WIDTH_W;

  rle62_pkg::phase_e phase_q, phase_d, phase_cur;
  logic [CW-1:0]      cnt_q, cnt_d, cnt_cur, digit;
  logic [PosBits-1:0] pos_q, pos_d, pos_cur, pos_run_end;

  logic               a_valid_q, b_valid_q;
  logic [PosBits-1:0] a_pos_q, b_pos_q, r0_pos, r1_pos;
  rle62_pkg::desc_t   a_desc_q, b_desc_q, r0, r1;
  logic               has0, has1, accept, is_esc;

  assign in_stall_o   = b_valid_q | (a_valid_q & ~desc_ready_i);
  assign accept       = in_valid_i & ~in_stall_o;
  assign desc_valid_o = a_valid_q;
  assign desc_pos_o   = a_pos_q;
  assign desc_o       = a_desc_q;

  // Base-62 digit; anything outside 0-9/A-Z is code minus 61, wrapped.
  always_comb begin
    if (code_byte_i >= rle62_pkg::CHAR_ZERO && code_byte_i <= rle62_pkg::CHAR_NINE) begin
      digit = CW'(code_byte_i - rle62_pkg::CHAR_ZERO);
    end else if (code_byte_i >= rle62_pkg::CHAR_A && code_byte_i <= rle62_pkg::CHAR_Z) begin
      digit = CW'(code_byte_i - rle62_pkg::CHAR_A) + CW'(10);
    end else begin
      digit = CW'(code_byte_i) - CW'(61);
    end
  end

  assign is_esc      = (code_byte_i == rle62_pkg::ESCAPE_BYTE);
  assign phase_cur   = start_of_image_i ? rle62_pkg::PH_IDLE : phase_q;
  assign cnt_cur     = start_of_image_i ? '0 : cnt_q;
  assign pos_cur     = start_of_image_i ? '0 : pos_q;
  assign pos_run_end = pos_cur + PosBits'(cnt_cur) - PosBits'(1);

  always_comb begin
    phase_d = phase_cur;
    cnt_d   = cnt_cur;
    pos_d   = pos_cur;
    has0    = 1'b0;
    has1    = 1'b0;
    r0_pos  = pos_cur;
    r1_pos  = pos_run_end;
    r0      = '{width: WW'(scale_i), color: digit[3:0], last: 1'b1};
    r1      = '{width: WW'(scale_i), color: digit[3:0], last: 1'b1};
    unique case (phase_cur)
      rle62_pkg::PH_DIGIT1: begin
        cnt_d   = (cnt_cur << 6) - (cnt_cur << 1) + digit;
        phase_d = rle62_pkg::PH_DIGIT2;
      end
      rle62_pkg::PH_DIGIT2: begin
        cnt_d   = (cnt_cur << 6) - (cnt_cur << 1) + digit;
        phase_d = rle62_pkg::PH_DIGIT3;
      end
      rle62_pkg::PH_DIGIT3: begin
        cnt_d   = (cnt_cur << 6) - (cnt_cur << 1) + digit;
        phase_d = rle62_pkg::PH_COLOR;
      end
      rle62_pkg::PH_COLOR: begin
        has0     = 1'b1;
        r0.width = WW'(cnt_cur) * WW'(scale_i);
        r0.last  = is_esc;
        if (is_esc) begin
          // escape as colour byte: run only, then a fresh escape
          pos_d   = pos_run_end;
          cnt_d   = '0;
          phase_d = rle62_pkg::PH_DIGIT1;
        end else begin
          has1    = 1'b1;
          pos_d   = pos_cur + PosBits'(cnt_cur);
          phase_d = rle62_pkg::PH_IDLE;
        end
      end
      default: begin
        if (is_esc) begin
          cnt_d   = '0;
          phase_d = rle62_pkg::PH_DIGIT1;
        end else begin
          has0    = 1'b1;
          pos_d   = pos_cur + PosBits'(1);
          phase_d = rle62_pkg::PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rle62_pkg::PH_IDLE;
      cnt_q     <= '0;
      pos_q     <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        pos_q   <= pos_d;
        // accept implies slot b is empty and slot a is free or draining
        a_valid_q <= has0 | (a_valid_q & ~desc_ready_i);
        b_valid_q <= has1;
      end else if (a_valid_q & desc_ready_i) begin
        a_valid_q <= b_valid_q;
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (has0) begin
        a_pos_q  <= r0_pos;
        a_desc_q <= r0;
      end
      if (has1) begin
        b_pos_q  <= r1_pos;
        b_desc_q <= r1;
      end
    end else if (a_valid_q & desc_ready_i & b_valid_q) begin
      a_pos_q  <= b_pos_q;
      a_desc_q <= b_desc_q;
    end
  end

endmodule

// File: sv/rle62_coord.sv
// Coordinate pipeline: position to column/row by reciprocal multiply, then scale and offset.
module rle62_coord #(
  parameter int LineWidth = rle62_pkg::LINE_WIDTH_DEF,
  parameter int PosBits   = rle62_pkg::POSITION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [15:0]                   origin_x_i,
  input  logic signed [15:0]                   origin_y_i,
  input  logic [3:0]                           scale_i,
  input  logic                                 desc_valid_i,
  output logic                                 desc_ready_o,
  input  logic [PosBits-1:0]                   desc_pos_i,
  input  rle62_pkg::desc_t                     desc_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rle62_pkg::COORD_W-1:0] rect_x_o,
  output logic signed [rle62_pkg::COORD_W-1:0] rect_y_o,
  output logic [rle62_pkg::WIDTH_W-1:0]        rect_width_o,
  output logic [3:0]                           rect_height_o,
  output logic [rle62_pkg::COLOR_W-1:0]        fill_color_o,
  output logic                                 last_of_run_o
);

  localparam int XW     = rle62_pkg::COORD_W;
  localparam int RecipK = PosBits + $clog2(LineWidth);
  localparam int RecipW = PosBits + 1;
  // wide enough that the quotient select below stays inside the product
  localparam int ProdW  = RecipK + PosBits;
  localparam int ColW   = $clog2(LineWidth + 1);
  // ceil(2^K / LineWidth): exact floor division for every PosBits-bit position
  localparam logic [63:0] RecipFull =
    ((64'd1 << RecipK) + 64'(LineWidth) - 64'd1) / 64'(LineWidth);
  localparam logic [RecipW-1:0] RecipM = RecipFull[RecipW-1:0];

  logic               v2_q, v3_q, v4_q, r2, r3, r4;
  logic [PosBits-1:0] pos2_q, q2_q, row3_q, rem3;
  logic [ProdW-1:0]   prod2;
  logic [ColW-1:0]    col3_q;
  rle62_pkg::desc_t   desc2_q, desc3_q;

  assign r4           = ~v4_q | ~out_stall_i;
  assign r3           = ~v3_q | r4;
  assign r2           = ~v2_q | r3;
  assign desc_ready_o = r2;
  assign out_valid_o  = v4_q;

  assign prod2 = ProdW'(desc_pos_i) * ProdW'(RecipM);
  assign rem3  = pos2_q - PosBits'(q2_q * PosBits'(LineWidth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r2) v2_q <= desc_valid_i;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2) begin
      pos2_q  <= desc_pos_i;
      q2_q    <= prod2[RecipK +: PosBits];
      desc2_q <= desc_i;
    end
    if (r3) begin
      col3_q  <= ColW'(rem3);
      row3_q  <= q2_q;
      desc3_q <= desc2_q;
    end
    if (r4) begin
      rect_x_o      <= XW'(origin_x_i) + XW'(XW'(col3_q) * XW'(scale_i));
      rect_y_o      <= XW'(origin_y_i) + XW'(XW'(row3_q) * XW'(scale_i));
      rect_width_o  <= desc3_q.width;
      rect_height_o <= scale_i;
      fill_color_o  <= rle62_pkg::palette(desc3_q.color);
      last_of_run_o <= desc3_q.last;
    end
  end

endmodule
